@@ rtl/core/tmts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmts_pkg
// Shared types and constants of the tiered merge task scheduler.
// ----------------------------------------------------------------------------
package tmts_pkg;

    localparam int MAX_FILES   = 64;
    localparam int ADDR_W      = $clog2(MAX_FILES);
    localparam int CNT_W       = $clog2(MAX_FILES + 1);
    localparam int MAX_LEVELS  = 8;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int FANIN_CAP   = 16;
    localparam int PEND_W      = $clog2(FANIN_CAP);
    localparam int K_W         = $clog2(FANIN_CAP + 1);
    localparam int FAN_W       = 5;
    localparam int ID_W        = 16;
    localparam int SIZE_W      = 32;
    localparam int TGT_W       = 7;
    localparam int MODE_W      = 3;
    localparam int STAT_W      = 3;

    localparam logic [FAN_W-1:0] FAN_IN_RESET = FAN_W'(8);
    localparam logic [FAN_W-1:0] FAN_IN_MIN   = FAN_W'(2);
    localparam logic [FAN_W-1:0] FAN_IN_MAX   = FAN_W'(FANIN_CAP);

    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MERGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FINAL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DONE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    localparam logic [STAT_W-1:0] ST_TASK   = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_OK     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BUSY   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [LVL_W-1:0]  lvl;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CNT   = 9'b000000010,
        S_COLL  = 9'b000000100,
        S_SEL   = 9'b000001000,
        S_FIND  = 9'b000010000,
        S_SHIFT = 9'b000100000,
        S_FIN   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    function automatic logic [LVL_W-1:0] sat_next(input logic [LVL_W-1:0] l);
        logic [LVL_W:0] s;
        s = {1'b0, l} + (LVL_W+1)'(1);
        if (s > (LVL_W+1)'(MAX_LEVELS - 1)) begin
            s = (LVL_W+1)'(MAX_LEVELS - 1);
        end
        return s[LVL_W-1:0];
    endfunction

endpackage

@@ rtl/core/tmts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tiered_merge_task_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_merge_task_scheduler_top
// File table with level-based and size-based merge task selection.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_ready | mode, file_id, file_bytes, target_count
// out     | output    | o_out_valid/i_out_ready | task_file_id, dest_level, file_count,
//         |           |                         | status, last
// cfg     | input     | i_cfg_valid/o_cfg_ready | fan_in
//
// Merge, final and done requests scan the file table through the one read port
// of the file RAM, once per pass. Synchronous active-low reset, no clearing pass.
// A stalled output holds the sequencer; one item is in work at a time.
// ----------------------------------------------------------------------------
module tiered_merge_task_scheduler_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tmts_pkg::MODE_W-1:0]  i_mode,
    input  logic [tmts_pkg::ID_W-1:0]    i_file_id,
    input  logic [tmts_pkg::SIZE_W-1:0]  i_file_bytes,
    input  logic [tmts_pkg::TGT_W-1:0]   i_target_count,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tmts_pkg::ID_W-1:0]    o_task_file_id,
    output logic [tmts_pkg::LVL_W-1:0]   o_dest_level,
    output logic [tmts_pkg::CNT_W-1:0]   o_file_count,
    output logic [tmts_pkg::STAT_W-1:0]  o_status,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tmts_pkg::FAN_W-1:0]   i_cfg_data
);

    localparam int AW = tmts_pkg::ADDR_W;
    localparam int CW = tmts_pkg::CNT_W;
    localparam int LW = tmts_pkg::LVL_W;
    localparam int KW = tmts_pkg::K_W;
    localparam int FW = tmts_pkg::FAN_W;
    localparam int TGTX_W = tmts_pkg::TGT_W + 1;

    tmts_pkg::t_state r_state, n_state;
    logic [FW-1:0]              r_fan_in, n_fan_in;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [KW-1:0]              r_pc, n_pc;
    logic [LW-1:0]              r_plvl, n_plvl;
    logic                       r_open, n_open;
    logic [tmts_pkg::ID_W-1:0]  r_id, n_id;
    logic [tmts_pkg::SIZE_W-1:0] r_size, n_size;
    logic [tmts_pkg::STAT_W-1:0] r_st, n_st;
    logic [CW-1:0]              r_ra, n_ra;
    logic                       r_pv, n_pv;
    logic [AW-1:0]              r_pi, n_pi;
    logic [KW-1:0]              r_k, n_k;
    logic [KW-1:0]              r_n, n_n;
    logic [LW-1:0]              r_lvl, n_lvl;
    logic [LW-1:0]              r_maxl, n_maxl;
    logic                       r_have, n_have;
    logic [tmts_pkg::SIZE_W-1:0] r_bsize, n_bsize;
    logic [LW-1:0]              r_blvl, n_blvl;
    logic [AW-1:0]              r_bidx, n_bidx;
    logic [tmts_pkg::ID_W-1:0]  r_bid, n_bid;
    logic [AW-1:0]              r_sh, n_sh;
    logic                       r_ph, n_ph;
    logic [tmts_pkg::MAX_FILES-1:0] r_taken, n_taken;
    logic [CW-1:0]              r_lcnt [tmts_pkg::MAX_LEVELS];
    logic [CW-1:0]              n_lcnt [tmts_pkg::MAX_LEVELS];
    logic [tmts_pkg::ID_W-1:0]  r_pend [tmts_pkg::FANIN_CAP];
    logic                       pend_we;
    logic [tmts_pkg::ID_W-1:0]  pend_wdata;

    logic                       r_ov, n_ov;
    logic [tmts_pkg::ID_W-1:0]  r_o_id, n_o_id;
    logic [LW-1:0]              r_o_lvl, n_o_lvl;
    logic [tmts_pkg::STAT_W-1:0] r_o_st, n_o_st;
    logic                       r_o_last, n_o_last;
    logic [CW-1:0]              r_o_cnt, n_o_cnt;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    tmts_pkg::t_entry           ram_wdata;
    logic [AW-1:0]              ram_raddr;
    tmts_pkg::t_entry           rd;
    logic [tmts_pkg::ENTRY_W-1:0] rd_bits;

    logic                       scanning, issue, scan_end, can_push, in_xfer;
    logic [tmts_pkg::ID_W-1:0]  pend_rd;
    logic [TGTX_W-1:0]          tgt;
    logic [TGTX_W-1:0]          nsel;
    logic                       lvl_hit;
    logic [LW-1:0]              lvl_found;
    logic                       better;
    logic [FW-1:0]              cfg_v;

    tmts_ram #(
        .WIDTH (tmts_pkg::ENTRY_W),
        .DEPTH (tmts_pkg::MAX_FILES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bits)
    );

    assign rd = tmts_pkg::t_entry'(rd_bits);

    assign o_in_ready  = (r_state == tmts_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign can_push    = !r_ov || i_out_ready;
    assign scanning    = (r_state == tmts_pkg::S_CNT) || (r_state == tmts_pkg::S_COLL) ||
                         (r_state == tmts_pkg::S_SEL) || (r_state == tmts_pkg::S_FIND);
    assign issue       = scanning && (r_ra < r_cnt);
    assign scan_end    = scanning && (r_ra == r_cnt) && !r_pv;
    assign pend_rd     = r_pend[r_k[tmts_pkg::PEND_W-1:0]];
    assign ram_raddr   = (r_state == tmts_pkg::S_SHIFT) ? AW'(r_sh + AW'(1)) : r_ra[AW-1:0];

    assign o_out_valid    = r_ov;
    assign o_task_file_id = r_o_id;
    assign o_dest_level   = r_o_lvl;
    assign o_file_count   = r_o_cnt;
    assign o_status       = r_o_st;
    assign o_last         = r_o_last;

    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v < tmts_pkg::FAN_IN_MIN) begin
            cfg_v = tmts_pkg::FAN_IN_MIN;
        end else if (cfg_v > tmts_pkg::FAN_IN_MAX) begin
            cfg_v = tmts_pkg::FAN_IN_MAX;
        end
    end

    always_comb begin
        tgt = {1'b0, i_target_count};
        if (tgt == '0) begin
            tgt = TGTX_W'(1);
        end
        nsel = TGTX_W'(r_cnt) - tgt + TGTX_W'(1);
        if (nsel > TGTX_W'(r_fan_in)) begin
            nsel = TGTX_W'(r_fan_in);
        end
    end

    always_comb begin
        lvl_hit   = 1'b0;
        lvl_found = '0;
        for (int l = tmts_pkg::MAX_LEVELS - 1; l >= 0; l--) begin
            if (r_lcnt[l] >= CW'(r_fan_in)) begin
                lvl_hit   = 1'b1;
                lvl_found = LW'(l);
            end
        end
    end

    assign better = !r_have || (rd.size < r_bsize) ||
                    ((rd.size == r_bsize) && (rd.lvl < r_blvl));

    always_comb begin
        n_state  = r_state;
        n_fan_in = r_fan_in;
        n_cnt    = r_cnt;
        n_pc     = r_pc;
        n_plvl   = r_plvl;
        n_open   = r_open;
        n_id     = r_id;
        n_size   = r_size;
        n_st     = r_st;
        n_ra     = r_ra;
        n_pv     = 1'b0;
        n_pi     = r_ra[AW-1:0];
        n_k      = r_k;
        n_n      = r_n;
        n_lvl    = r_lvl;
        n_maxl   = r_maxl;
        n_have   = r_have;
        n_bsize  = r_bsize;
        n_blvl   = r_blvl;
        n_bidx   = r_bidx;
        n_bid    = r_bid;
        n_sh     = r_sh;
        n_ph     = r_ph;
        n_taken  = r_taken;
        n_lcnt   = r_lcnt;
        pend_we    = 1'b0;
        pend_wdata = r_bid;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[AW-1:0];
        ram_wdata  = '{id: r_id, size: r_size, lvl: r_plvl};
        n_ov     = r_ov && !i_out_ready;
        n_o_id   = r_o_id;
        n_o_lvl  = r_o_lvl;
        n_o_st   = r_o_st;
        n_o_last = r_o_last;
        n_o_cnt  = r_o_cnt;

        if (i_cfg_valid) begin
            n_fan_in = cfg_v;
        end

        if (issue) begin
            n_ra = r_ra + CW'(1);
            n_pv = 1'b1;
        end

        case (r_state)
            tmts_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_id    = i_file_id;
                    n_size  = i_file_bytes;
                    n_ra    = '0;
                    n_k     = '0;
                    n_have  = 1'b0;
                    n_state = tmts_pkg::S_RESP;
                    case (i_mode)
                        tmts_pkg::MODE_ADD: begin
                            if (r_cnt >= CW'(tmts_pkg::MAX_FILES)) begin
                                n_st = tmts_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = '{id: i_file_id, size: i_file_bytes, lvl: '0};
                                n_cnt     = r_cnt + CW'(1);
                                n_st      = tmts_pkg::ST_OK;
                            end
                        end
                        tmts_pkg::MODE_MERGE: begin
                            if (r_open) begin
                                n_st = tmts_pkg::ST_BUSY;
                            end else begin
                                for (int l = 0; l < tmts_pkg::MAX_LEVELS; l++) begin
                                    n_lcnt[l] = '0;
                                end
                                n_state = tmts_pkg::S_CNT;
                            end
                        end
                        tmts_pkg::MODE_FINAL: begin
                            if (r_open) begin
                                n_st = tmts_pkg::ST_BUSY;
                            end else if (TGTX_W'(r_cnt) <= tgt) begin
                                n_st = tmts_pkg::ST_NONE;
                            end else begin
                                n_n     = KW'(nsel);
                                n_maxl  = '0;
                                n_taken = '0;
                                n_state = tmts_pkg::S_SEL;
                            end
                        end
                        tmts_pkg::MODE_DONE: begin
                            if (!r_open) begin
                                n_st = tmts_pkg::ST_BUSY;
                            end else begin
                                n_state = tmts_pkg::S_FIND;
                            end
                        end
                        tmts_pkg::MODE_CLEAR: begin
                            n_cnt  = '0;
                            n_pc   = '0;
                            n_open = 1'b0;
                            n_st   = tmts_pkg::ST_OK;
                        end
                        default: begin
                            n_st = tmts_pkg::ST_NONE;
                        end
                    endcase
                end
            end
            tmts_pkg::S_CNT: begin
                if (r_pv) begin
                    n_lcnt[rd.lvl] = r_lcnt[rd.lvl] + CW'(1);
                end
                if (scan_end) begin
                    if (!lvl_hit) begin
                        n_st    = tmts_pkg::ST_NONE;
                        n_state = tmts_pkg::S_RESP;
                    end else begin
                        n_lvl   = lvl_found;
                        n_plvl  = tmts_pkg::sat_next(lvl_found);
                        n_ra    = '0;
                        n_k     = '0;
                        n_state = tmts_pkg::S_COLL;
                    end
                end
            end
            tmts_pkg::S_COLL: begin
                if (r_pv && (rd.lvl == r_lvl) && (r_k < KW'(r_fan_in))) begin
                    pend_we    = 1'b1;
                    pend_wdata = rd.id;
                    n_k        = r_k + KW'(1);
                end
                if (scan_end) begin
                    n_pc    = r_k;
                    n_open  = 1'b1;
                    n_k     = '0;
                    n_state = tmts_pkg::S_EMIT;
                end
            end
            tmts_pkg::S_SEL: begin
                if (r_pv && !r_taken[r_pi] && better) begin
                    n_have  = 1'b1;
                    n_bsize = rd.size;
                    n_blvl  = rd.lvl;
                    n_bidx  = r_pi;
                    n_bid   = rd.id;
                end
                if (scan_end) begin
                    n_taken[r_bidx] = 1'b1;
                    pend_we    = 1'b1;
                    pend_wdata = r_bid;
                    if (r_blvl > r_maxl) begin
                        n_maxl = r_blvl;
                    end
                    n_have = 1'b0;
                    n_ra   = '0;
                    n_k    = r_k + KW'(1);
                    if (r_k + KW'(1) == r_n) begin
                        n_pc    = r_n;
                        n_plvl  = tmts_pkg::sat_next((r_blvl > r_maxl) ? r_blvl : r_maxl);
                        n_open  = 1'b1;
                        n_k     = '0;
                        n_state = tmts_pkg::S_EMIT;
                    end
                end
            end
            tmts_pkg::S_FIND: begin
                if (r_pv && (rd.id == pend_rd) && (!r_have || (rd.lvl < r_blvl))) begin
                    n_have = 1'b1;
                    n_blvl = rd.lvl;
                    n_bidx = r_pi;
                end
                if (scan_end) begin
                    if (r_have) begin
                        n_sh    = r_bidx;
                        n_ph    = 1'b0;
                        n_state = tmts_pkg::S_SHIFT;
                    end else begin
                        n_k  = r_k + KW'(1);
                        n_ra = '0;
                        if (r_k + KW'(1) == r_pc) begin
                            n_state = tmts_pkg::S_FIN;
                        end
                    end
                end
            end
            tmts_pkg::S_SHIFT: begin
                if (r_ph) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_sh;
                    ram_wdata = rd;
                    n_sh      = r_sh + AW'(1);
                    n_ph      = 1'b0;
                end else if (CW'(r_sh) + CW'(1) < r_cnt) begin
                    n_ph = 1'b1;
                end else begin
                    n_cnt  = r_cnt - CW'(1);
                    n_have = 1'b0;
                    n_k    = r_k + KW'(1);
                    n_ra   = '0;
                    if (r_k + KW'(1) == r_pc) begin
                        n_state = tmts_pkg::S_FIN;
                    end else begin
                        n_state = tmts_pkg::S_FIND;
                    end
                end
            end
            tmts_pkg::S_FIN: begin
                n_open  = 1'b0;
                n_pc    = '0;
                n_state = tmts_pkg::S_RESP;
                if (r_cnt >= CW'(tmts_pkg::MAX_FILES)) begin
                    n_st = tmts_pkg::ST_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_st   = tmts_pkg::ST_OK;
                end
            end
            tmts_pkg::S_EMIT: begin
                if (can_push) begin
                    n_ov     = 1'b1;
                    n_o_id   = pend_rd;
                    n_o_lvl  = r_plvl;
                    n_o_st   = tmts_pkg::ST_TASK;
                    n_o_cnt  = r_cnt;
                    n_o_last = (r_k + KW'(1) == r_pc);
                    n_k      = r_k + KW'(1);
                    if (r_k + KW'(1) == r_pc) begin
                        n_state = tmts_pkg::S_IDLE;
                    end
                end
            end
            tmts_pkg::S_RESP: begin
                if (can_push) begin
                    n_ov     = 1'b1;
                    n_o_id   = '0;
                    n_o_lvl  = '0;
                    n_o_st   = r_st;
                    n_o_cnt  = r_cnt;
                    n_o_last = 1'b1;
                    n_state  = tmts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tmts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tmts_pkg::S_IDLE;
            r_fan_in <= tmts_pkg::FAN_IN_RESET;
            r_cnt    <= '0;
            r_pc     <= '0;
            r_plvl   <= '0;
            r_open   <= 1'b0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fan_in <= n_fan_in;
            r_cnt    <= n_cnt;
            r_pc     <= n_pc;
            r_plvl   <= n_plvl;
            r_open   <= n_open;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_size   <= n_size;
        r_st     <= n_st;
        r_ra     <= n_ra;
        r_pi     <= n_pi;
        r_k      <= n_k;
        r_n      <= n_n;
        r_lvl    <= n_lvl;
        r_maxl   <= n_maxl;
        r_have   <= n_have;
        r_bsize  <= n_bsize;
        r_blvl   <= n_blvl;
        r_bidx   <= n_bidx;
        r_bid    <= n_bid;
        r_sh     <= n_sh;
        r_ph     <= n_ph;
        r_taken  <= n_taken;
        r_lcnt   <= n_lcnt;
        r_o_id   <= n_o_id;
        r_o_lvl  <= n_o_lvl;
        r_o_st   <= n_o_st;
        r_o_last <= n_o_last;
        r_o_cnt  <= n_o_cnt;
        if (pend_we) begin
            r_pend[r_k[tmts_pkg::PEND_W-1:0]] <= pend_wdata;
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the tiered merge task scheduler. Adds, merge and final
// requests, merge completions, clears and unknown modes go through the input
// channel. Fan-in is written between phases. Each accepted input updates a
// file-table model that predicts the results, and each output transfer is
// checked in order. Sender and receiver stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import tmts_pkg::*;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [LVL_W-1:0]  lvl;
        logic [CNT_W-1:0]  cnt;
        logic [STAT_W-1:0] st;
        logic              last;
    } t_result;

    class merge_scoreboard;
        logic [ID_W-1:0]   ids   [MAX_FILES];
        logic [SIZE_W-1:0] sizes [MAX_FILES];
        logic [LVL_W-1:0]  lvls  [MAX_FILES];
        int                cnt;
        logic [ID_W-1:0]   pend_ids [FANIN_CAP];
        int                pend_cnt;
        logic [LVL_W-1:0]  pend_lvl;
        bit                open;
        int                fan;
        t_result           results_q[$];
        int                errors;

        function new();
            cnt = 0; pend_cnt = 0; pend_lvl = '0; open = 0; fan = 8; errors = 0;
        endfunction

        function void set_fan_in(logic [FAN_W-1:0] v);
            fan = (v < 2) ? 2 : (v > FANIN_CAP) ? FANIN_CAP : int'(v);
        endfunction

        function void push(logic [ID_W-1:0] id, logic [LVL_W-1:0] l,
                           logic [STAT_W-1:0] st, bit last);
            t_result r;
            r.id = id; r.lvl = l; r.cnt = CNT_W'(cnt); r.st = st; r.last = last;
            results_q = {results_q, r};
        endfunction

        function void append(logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz,
                             logic [LVL_W-1:0] l);
            ids[cnt] = id; sizes[cnt] = sz; lvls[cnt] = l;
            cnt++;
        endfunction

        function void remove_file(logic [ID_W-1:0] id);
            int hit;
            hit = -1;
            for (int i = 0; i < cnt; i++)
                if (ids[i] == id && (hit < 0 || lvls[i] < lvls[hit])) hit = i;
            if (hit < 0) return;
            for (int i = hit; i + 1 < cnt; i++) begin
                ids[i] = ids[i+1]; sizes[i] = sizes[i+1]; lvls[i] = lvls[i+1];
            end
            cnt--;
        endfunction

        function logic [LVL_W-1:0] next_level(int l);
            return (l >= MAX_LEVELS - 1) ? LVL_W'(MAX_LEVELS - 1) : LVL_W'(l + 1);
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                 logic [SIZE_W-1:0] sz, logic [TGT_W-1:0] tgt);
            int  lvl, c, k, n, t, best, maxl;
            bit  taken [MAX_FILES];
            case (mode)
                MODE_ADD: begin
                    if (cnt >= MAX_FILES) begin
                        push('0, '0, ST_FULL, 1);
                    end else begin
                        append(id, sz, '0);
                        push('0, '0, ST_OK, 1);
                    end
                end
                MODE_MERGE, MODE_FINAL: begin
                    if (open) begin
                        push('0, '0, ST_BUSY, 1);
                        return;
                    end
                    k = 0;
                    if (mode == MODE_MERGE) begin
                        lvl = -1;
                        for (int l = 0; l < MAX_LEVELS && lvl < 0; l++) begin
                            c = 0;
                            for (int i = 0; i < cnt; i++) if (lvls[i] == l) c++;
                            if (c >= fan) lvl = l;
                        end
                        if (lvl < 0) begin
                            push('0, '0, ST_NONE, 1);
                            return;
                        end
                        pend_lvl = next_level(lvl);
                        for (int i = 0; i < cnt && k < fan; i++)
                            if (lvls[i] == lvl) pend_ids[k++] = ids[i];
                    end else begin
                        t = (tgt == 0) ? 1 : int'(tgt);
                        if (cnt <= t) begin
                            push('0, '0, ST_NONE, 1);
                            return;
                        end
                        n = cnt - t + 1;
                        if (n > fan) n = fan;
                        foreach (taken[i]) taken[i] = 0;
                        maxl = 0;
                        for (k = 0; k < n; k++) begin
                            best = -1;
                            for (int i = 0; i < cnt; i++) begin
                                if (taken[i]) continue;
                                if (best < 0 || sizes[i] < sizes[best] ||
                                    (sizes[i] == sizes[best] && lvls[i] < lvls[best]))
                                    best = i;
                            end
                            taken[best] = 1;
                            pend_ids[k] = ids[best];
                            if (lvls[best] > maxl) maxl = lvls[best];
                        end
                        pend_lvl = next_level(maxl);
                    end
                    pend_cnt = k;
                    open = 1;
                    for (int i = 0; i < pend_cnt; i++)
                        push(pend_ids[i], pend_lvl, ST_TASK, i + 1 == pend_cnt);
                end
                MODE_DONE: begin
                    if (!open) begin
                        push('0, '0, ST_BUSY, 1);
                        return;
                    end
                    for (int i = 0; i < pend_cnt; i++) remove_file(pend_ids[i]);
                    open = 0;
                    pend_cnt = 0;
                    if (cnt >= MAX_FILES) begin
                        push('0, '0, ST_FULL, 1);
                    end else begin
                        append(id, sz, pend_lvl);
                        push('0, '0, ST_OK, 1);
                    end
                end
                MODE_CLEAR: begin
                    cnt = 0; pend_cnt = 0; open = 0;
                    push('0, '0, ST_OK, 1);
                end
                default: push('0, '0, ST_NONE, 1);
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (results_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: id %0h lvl %0d cnt %0d st %0d last %0b",
                             got.id, got.lvl, got.cnt, got.st, got.last);
                return;
            end
            exp = results_q.pop_front();
            if (got.id !== exp.id || got.lvl !== exp.lvl || got.cnt !== exp.cnt ||
                got.st !== exp.st || got.last !== exp.last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp id %0h lvl %0d cnt %0d st %0d last %0b,",
                              " got id %0h lvl %0d cnt %0d st %0d last %0b"},
                             exp.id, exp.lvl, exp.cnt, exp.st, exp.last,
                             got.id, got.lvl, got.cnt, got.st, got.last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [MODE_W-1:0]  i_mode;
    logic [ID_W-1:0]    i_file_id;
    logic [SIZE_W-1:0]  i_file_bytes;
    logic [TGT_W-1:0]   i_target_count;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [ID_W-1:0]    o_task_file_id;
    logic [LVL_W-1:0]   o_dest_level;
    logic [CNT_W-1:0]   o_file_count;
    logic [STAT_W-1:0]  o_status;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [FAN_W-1:0]   i_cfg_data;

    merge_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;

    tiered_merge_task_scheduler_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_result r;
                r.id = o_task_file_id; r.lvl = o_dest_level; r.cnt = o_file_count;
                r.st = o_status; r.last = o_last;
                sb.check_result(r);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                             logic [SIZE_W-1:0] sz, logic [TGT_W-1:0] tgt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_file_id      <= id;
        i_file_bytes   <= sz;
        i_target_count <= tgt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(mode, id, sz, tgt);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.results_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_fan_in(logic [FAN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_fan_in(v);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [ID_W-1:0] rand_id();
        return ($urandom_range(1) != 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        return ($urandom_range(1) != 0) ? SIZE_W'($urandom_range(3)) : SIZE_W'($urandom);
    endfunction

    task automatic random_phase(int quota);
        int stop, adds;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            if ($urandom_range(99) < 70) begin
                adds = $urandom_range(sb.fan + 3);
                repeat (adds) send_item(MODE_ADD, rand_id(), rand_size(), TGT_W'($urandom));
                if ($urandom_range(1) != 0)
                    send_item(MODE_MERGE, rand_id(), rand_size(), TGT_W'($urandom));
                else
                    send_item(MODE_FINAL, rand_id(), rand_size(),
                              TGT_W'($urandom_range(sb.cnt + 1)));
                if ($urandom_range(3) == 0)
                    send_item(MODE_ADD, rand_id(), rand_size(), TGT_W'($urandom));
                send_item(MODE_DONE, rand_id(), rand_size(), TGT_W'($urandom));
            end else begin
                send_item(MODE_W'($urandom_range(7)), rand_id(), rand_size(),
                          TGT_W'($urandom));
            end
            if ($urandom_range(19) == 0)
                send_item(MODE_CLEAR, rand_id(), rand_size(), TGT_W'($urandom));
        end
    endtask

    initial begin
        sb = new();
        items_sent     = 0;
        send_idle_pct  = 29;
        recv_idle_pct  = 84;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_ADD;
        i_file_id      = '0;
        i_file_bytes   = '0;
        i_target_count = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset fan-in, extremes, busy paths, unknown modes
        send_item(MODE_MERGE, '0, '0, '0);
        send_item(MODE_FINAL, '0, '0, '0);
        send_item(MODE_DONE, '1, '1, '1);
        send_item(MODE_ADD, '0, '0, '0);
        send_item(MODE_ADD, '1, '1, '1);
        send_item(MODE_ADD, 16'h1234, 32'd5, 7'd64);
        send_item(MODE_FINAL, '0, '0, 7'd127);
        send_item(MODE_FINAL, '0, '0, '0);
        send_item(MODE_MERGE, '0, '0, '0);
        send_item(MODE_FINAL, '0, '0, 7'd1);
        send_item(MODE_ADD, 16'h00ff, 32'h8000_0000, '0);
        send_item(MODE_DONE, 16'hbeef, 32'd7, '0);
        send_item(MODE_DONE, '0, '0, '0);
        send_item(3'd5, '1, '1, '1);
        send_item(3'd6, '0, '0, '0);
        send_item(3'd7, '1, '0, '1);
        send_item(MODE_FINAL, '0, '0, 7'd1);
        send_item(MODE_CLEAR, '0, '0, '0);
        send_item(MODE_DONE, '0, '0, '0);

        write_fan_in(5'd0);
        send_idle_pct = 29; recv_idle_pct = 84;
        random_phase(90);

        write_fan_in(5'd31);
        send_idle_pct = 84; recv_idle_pct = 29;
        send_item(MODE_CLEAR, '0, '0, '0);
        while (sb.cnt < MAX_FILES) send_item(MODE_ADD, rand_id(), rand_size(), '0);
        send_item(MODE_ADD, '1, '1, '0);
        send_item(MODE_MERGE, '0, '0, '0);
        send_item(MODE_ADD, '1, '1, '0);
        send_item(MODE_DONE, '1, '1, '0);
        send_item(MODE_FINAL, '0, '0, 7'd1);
        send_item(MODE_DONE, 16'h4242, '0, '0);
        send_item(MODE_CLEAR, '0, '0, '0);
        random_phase(40);

        write_fan_in(5'($urandom_range(3, 8)));
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(30);
        write_fan_in(5'd17);
        write_fan_in(5'd2);
        random_phase(25);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
